[sv/gray_transfer_curve_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// gray transfer curve generator assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef GRAY_TRANSFER_CURVE_GENERATOR_UNIT_DEFINES_SVH
`define GRAY_TRANSFER_CURVE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define GTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtc assertion failed");

// next-cycle implication, off during reset
`define GTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtc assertion failed");

// next-cycle implication, also checked through reset
`define GTC_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gtc assertion failed");

`endif

[sv/gtc_pkg.sv]
// ----------------------------------------------------------------------------
// gtc_pkg
// widths, codes and the log curve rom for the gray transfer curve generator
// ----------------------------------------------------------------------------
`default_nettype none

package gtc_pkg;

  localparam int IW              = 17;
  localparam int CFG_W           = 16;
  localparam int GRAY_W          = 8;
  localparam int LOG_FRAC_BITS   = 10;
  localparam int MAX_SAMPLE_BITS = 16;
  localparam int QW              = LOG_FRAC_BITS + 1;
  localparam int DW              = 3 * IW;
  localparam int RW              = DW + QW;
  localparam int LOG_ROM_DEPTH   = (1 << LOG_FRAC_BITS) + 1;

  localparam logic [2:0] MODE_LOG    = 3'd0;
  localparam logic [2:0] MODE_LINEAR = 3'd1;
  localparam logic [2:0] MODE_SQUARE = 3'd2;
  localparam logic [2:0] MODE_CUBE   = 3'd3;
  localparam logic [2:0] MODE_WINDOW = 3'd4;

  localparam logic [1:0] REG_CURVE_MODE  = 2'd0;
  localparam logic [1:0] REG_RANGE_LOW   = 2'd1;
  localparam logic [1:0] REG_RANGE_HIGH  = 2'd2;
  localparam logic [1:0] REG_SAMPLE_BITS = 2'd3;

  typedef struct packed {
    logic is_log;
    logic kill;
    logic flag;
  } side_t;

  typedef logic [GRAY_W-1:0] log_rom_t [LOG_ROM_DEPTH];

  // log10 of 1+9q/2^F by repeated squaring, scaled to 255
  function automatic logic [GRAY_W-1:0] log_entry(input int unsigned qq);
    logic [63:0] bq;
    logic [63:0] m;
    logic [63:0] l;
    bq = (64'd1 << LOG_FRAC_BITS) + 64'd9 * 64'(qq);
    l  = '0;
    if (bq >= (64'd10 << LOG_FRAC_BITS)) begin
      return 8'd255;
    end
    m = bq << (28 - LOG_FRAC_BITS);
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 28;
      l = l << 1;
      if (m >= (64'd10 << 28)) begin
        l = l | 64'd1;
        m = m / 64'd10;
      end
    end
    l = (64'd255 * l) >> 24;
    return (l > 64'd255) ? 8'd255 : l[GRAY_W-1:0];
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t r;
    for (int q = 0; q < LOG_ROM_DEPTH; q++) begin
      r[q] = log_entry(q);
    end
    return r;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

[sv/gray_transfer_curve_generator_unit.sv]
// ----------------------------------------------------------------------------
// gray_transfer_curve_generator_unit
// gray-level transfer table entry per index: log, linear, square, cube, window
// ----------------------------------------------------------------------------
// usage:
//   write curve_mode, range_low, range_high and sample_bits through the
//   cfg_we / cfg_index / cfg_data port while no item is in flight
//   table_index items enter on in_valid/in_ready, one per cycle at best
//   each item gives one result on out_valid/out_ready: gray_value and
//   out_of_range
// pipeline: input stage, two multiply stages, operand select, 11 divider
//   stages, rom/output register
// throughput: one item per cycle unless stalled; every stage, including
//   each divider bit stage, is its own register, so items stream back to back
// reset: clears all stage valid bits and loads curve_mode linear,
//   range 0..255, sample_bits 8
// stall: a held output keeps its item; stages behind it keep filling
//   empty slots, and in_ready drops only once the pipe is full
// ----------------------------------------------------------------------------
`default_nettype none

module gray_transfer_curve_generator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [gtc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gtc_pkg::IW-1:0]     table_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gtc_pkg::GRAY_W-1:0] gray_value,
  output logic                       out_of_range
);

  localparam int IW = gtc_pkg::IW;
  localparam int DW = gtc_pkg::DW;
  localparam int RW = gtc_pkg::RW;
  localparam int QW = gtc_pkg::QW;

  // configuration registers
  logic [2:0]  curve_mode;
  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [4:0]  sample_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= gtc_pkg::MODE_LINEAR;
      range_low   <= 16'd0;
      range_high  <= 16'd255;
      sample_bits <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtc_pkg::REG_CURVE_MODE:  curve_mode  <= cfg_data[2:0];
        gtc_pkg::REG_RANGE_LOW:   range_low   <= cfg_data;
        gtc_pkg::REG_RANGE_HIGH:  range_high  <= cfg_data;
        gtc_pkg::REG_SAMPLE_BITS: sample_bits <= cfg_data[4:0];
      endcase
    end
  end

  // ready chain, output end first
  logic rdy_o, rdy1, rdy2, rdy3, rdy4, div_in_ready;
  logic v1, v2, v3, v4;

  assign rdy_o    = !out_valid || out_ready;
  assign rdy4     = !v4 || div_in_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: table size, window nodes, special cases
  logic [IW-1:0] n_c;
  logic          inv_c;
  logic [4:0]    bits_c;
  logic [3:0]    shift_c;
  logic [15:0]   n1_c, n2_c;
  logic          in_win_c;
  logic          kill_c, flag_c;

  always_comb begin
    n_c   = IW'(range_high) - IW'(range_low) + IW'(1);
    inv_c = (range_high < range_low);
    priority if (sample_bits < 5'd8) begin
      bits_c = 5'd8;
    end else if (sample_bits > 5'(gtc_pkg::MAX_SAMPLE_BITS)) begin
      bits_c = 5'(gtc_pkg::MAX_SAMPLE_BITS);
    end else begin
      bits_c = sample_bits;
    end
    shift_c  = 4'(bits_c - 5'd8);
    n1_c     = range_low >> shift_c;
    n2_c     = range_high >> shift_c;
    in_win_c = (IW'(n1_c) <= table_index) && (table_index < IW'(n2_c));

    // kill forces a zero entry, flag marks out of range
    priority if (curve_mode > gtc_pkg::MODE_WINDOW) begin
      kill_c = 1'b1;
      flag_c = 1'b0;
    end else if (inv_c) begin
      kill_c = 1'b1;
      flag_c = 1'b1;
    end else if (curve_mode == gtc_pkg::MODE_WINDOW) begin
      flag_c = (table_index > IW'(255));
      kill_c = flag_c || !in_win_c;
    end else begin
      flag_c = (table_index > n_c);
      kill_c = flag_c || (table_index == '0);
    end
  end

  logic [IW-1:0] s1_i, s1_n;
  logic [2:0]    s1_mode;
  logic          s1_kill, s1_flag;
  logic [7:0]    s1_wnum;
  logic [15:0]   s1_wden;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_i    <= table_index;
      s1_n    <= n_c;
      s1_mode <= curve_mode;
      s1_kill <= kill_c;
      s1_flag <= flag_c;
      s1_wnum <= 8'(table_index - IW'(n1_c));
      s1_wden <= n2_c - n1_c;
    end
  end

  // stage 2: squares
  logic [IW-1:0]   s2_i, s2_n;
  logic [2*IW-1:0] s2_i2, s2_n2;
  logic [2:0]      s2_mode;
  logic            s2_kill, s2_flag;
  logic [7:0]      s2_wnum;
  logic [15:0]     s2_wden;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_i    <= s1_i;
      s2_n    <= s1_n;
      s2_i2   <= (2*IW)'(s1_i) * (2*IW)'(s1_i);
      s2_n2   <= (2*IW)'(s1_n) * (2*IW)'(s1_n);
      s2_mode <= s1_mode;
      s2_kill <= s1_kill;
      s2_flag <= s1_flag;
      s2_wnum <= s1_wnum;
      s2_wden <= s1_wden;
    end
  end

  // stage 3: cubes
  logic [IW-1:0]   s3_i, s3_n;
  logic [2*IW-1:0] s3_i2, s3_n2;
  logic [DW-1:0]   s3_i3, s3_n3;
  logic [2:0]      s3_mode;
  logic            s3_kill, s3_flag;
  logic [7:0]      s3_wnum;
  logic [15:0]     s3_wden;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_i    <= s2_i;
      s3_n    <= s2_n;
      s3_i2   <= s2_i2;
      s3_n2   <= s2_n2;
      s3_i3   <= DW'(s2_i2) * DW'(s2_i);
      s3_n3   <= DW'(s2_n2) * DW'(s2_n);
      s3_mode <= s2_mode;
      s3_kill <= s2_kill;
      s3_flag <= s2_flag;
      s3_wnum <= s2_wnum;
      s3_wden <= s2_wden;
    end
  end

  // stage 4: pick dividend and divisor, scale by 255 as x*256 - x, or by 2^F for log
  logic [RW-1:0]  x_c;
  logic [RW-1:0]  num_c;
  logic [DW-1:0]  den_c;

  always_comb begin
    x_c   = '0;
    den_c = DW'(1);
    unique case (s3_mode)
      gtc_pkg::MODE_LOG: begin
        x_c   = RW'(s3_i);
        den_c = DW'(s3_n);
      end
      gtc_pkg::MODE_LINEAR: begin
        x_c   = RW'(s3_i);
        den_c = DW'(s3_n);
      end
      gtc_pkg::MODE_SQUARE: begin
        x_c   = RW'(s3_i2);
        den_c = DW'(s3_n2);
      end
      gtc_pkg::MODE_CUBE: begin
        x_c   = RW'(s3_i3);
        den_c = s3_n3;
      end
      gtc_pkg::MODE_WINDOW: begin
        x_c   = RW'(s3_wnum);
        den_c = DW'(s3_wden);
      end
      default: begin
        x_c   = '0;
        den_c = DW'(1);
      end
    endcase
    if (s3_mode == gtc_pkg::MODE_LOG) begin
      num_c = x_c << gtc_pkg::LOG_FRAC_BITS;
    end else begin
      num_c = (x_c << 8) - x_c;
    end
    if (s3_kill) begin
      num_c = '0;
      den_c = DW'(1);
    end
  end

  logic [RW-1:0]  s4_num;
  logic [DW-1:0]  s4_den;
  gtc_pkg::side_t s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_num         <= num_c;
      s4_den         <= den_c;
      s4_side.is_log <= (s3_mode == gtc_pkg::MODE_LOG);
      s4_side.kill   <= s3_kill;
      s4_side.flag   <= s3_flag;
    end
  end

  // divider: quotient never exceeds 2^F, since index <= table size
  logic           div_valid;
  logic [QW-1:0]  div_quo;
  gtc_pkg::side_t div_side;

  gtc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .in_num    (s4_num),
    .in_den    (s4_den),
    .in_side   (s4_side),
    .out_valid (div_valid),
    .out_ready (rdy_o),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // output register, doubles as the registered log rom read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      if (div_side.kill) begin
        gray_value <= '0;
      end else if (div_side.is_log) begin
        gray_value <= gtc_pkg::LOG_ROM[div_quo];
      end else begin
        gray_value <= div_quo[gtc_pkg::GRAY_W-1:0];
      end
      out_of_range <= div_side.flag;
    end
  end

endmodule

`default_nettype wire

[sv/gtc_div_pipe.sv]
// ----------------------------------------------------------------------------
// gtc_div_pipe
// restoring divider, one quotient bit per stage, with elastic stage control
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_div_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gtc_pkg::RW-1:0]     in_num,
  input  logic [gtc_pkg::DW-1:0]     in_den,
  input  gtc_pkg::side_t             in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gtc_pkg::QW-1:0]     out_quo,
  output gtc_pkg::side_t             out_side
);

  localparam int QW = gtc_pkg::QW;
  localparam int RW = gtc_pkg::RW;
  localparam int DW = gtc_pkg::DW;

  logic           v    [QW];
  logic [RW-1:0]  rem  [QW];
  logic [DW-1:0]  den  [QW];
  logic [QW-1:0]  quo  [QW];
  gtc_pkg::side_t side [QW];
  logic           rdy  [QW+1];

  // a stage takes a new item when empty or when its item moves on
  always_comb begin
    rdy[QW] = out_ready;
    for (int j = QW - 1; j >= 0; j--) begin
      rdy[j] = !v[j] || rdy[j+1];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic           src_v;
    logic [RW-1:0]  src_rem;
    logic [DW-1:0]  src_den;
    logic [QW-1:0]  src_quo;
    gtc_pkg::side_t src_side;
    logic [RW-1:0]  trial;
    logic           take;

    if (j == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rem  = in_num;
      assign src_den  = in_den;
      assign src_quo  = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v[j-1];
      assign src_rem  = rem[j-1];
      assign src_den  = den[j-1];
      assign src_quo  = quo[j-1];
      assign src_side = side[j-1];
    end

    assign trial = RW'(src_den) << B;
    assign take  = (src_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rem[j]  <= take ? (src_rem - trial) : src_rem;
        den[j]  <= src_den;
        quo[j]  <= {src_quo[QW-2:0], take};
        side[j] <= src_side;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

`default_nettype wire

[sv/gtc_checker.sv]
// ----------------------------------------------------------------------------
// gtc_checker
// port-level checks on the gray transfer curve generator
// ----------------------------------------------------------------------------
`default_nettype none

`include "gray_transfer_curve_generator_unit_defines.svh"

module gtc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gtc_pkg::GRAY_W-1:0] gray_value,
  input logic                       out_of_range
);

  // nothing comes out the cycle after reset
  `GTC_ASSERT_RST(a_reset_empty, clk, rst, !out_valid)

  // a flagged entry is always zero
  `GTC_ASSERT_IMP(a_flag_zero, clk, rst, out_valid && out_of_range, gray_value == 8'd0)

  // input only backs up behind a held result
  `GTC_ASSERT_IMP(a_ready_backpressure, clk, rst, !in_ready, out_valid && !out_ready)

  // a stalled result holds
  `GTC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(gray_value) && $stable(out_of_range))

endmodule

bind gray_transfer_curve_generator_unit gtc_checker u_gtc_checker (.*);

`default_nettype wire
